// ===== design/scts_pkg.sv =====
`default_nettype none

package scts_pkg;

  localparam int COORD_WIDTH_DEF = 24;

  typedef enum logic [1:0] {
    MODE_SEGMENT  = 2'd0,
    MODE_CAPSULE  = 2'd1,
    MODE_TRIANGLE = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    REG_SHAPE_MODE = 3'd0,
    REG_VERTEX_A_X = 3'd1,
    REG_VERTEX_A_Y = 3'd2,
    REG_VERTEX_B_X = 3'd3,
    REG_VERTEX_B_Y = 3'd4,
    REG_VERTEX_C_X = 3'd5,
    REG_VERTEX_C_Y = 3'd6,
    REG_RADIUS     = 3'd7
  } reg_idx_t;

  // sign of the cross product of (p - a) and (b - a)
  typedef struct packed {
    logic neg;
    logic pos;
  } side_t;

  // stage counts are front end 6, divider 2w+2, square root w+1
  function automatic int edge_latency(input int w);
    return 3 * w + 9;
  endfunction

endpackage

`default_nettype wire

// ===== design/scts_edge.sv =====
`default_nettype none

module scts_edge #(
  parameter int COORD_WIDTH = scts_pkg::COORD_WIDTH_DEF
) (
  input  wire                          clk,
  input  wire                          en,
  input  wire signed [COORD_WIDTH-1:0] px,
  input  wire signed [COORD_WIDTH-1:0] py,
  input  wire signed [COORD_WIDTH-1:0] ax,
  input  wire signed [COORD_WIDTH-1:0] ay,
  input  wire signed [COORD_WIDTH-1:0] bx,
  input  wire signed [COORD_WIDTH-1:0] by,
  output logic [COORD_WIDTH:0]         edist,
  output scts_pkg::side_t              side
);

  localparam int DFW      = COORD_WIDTH + 1;
  localparam int PW       = 2 * DFW;
  localparam int SW       = PW + 1;
  localparam int CW       = PW;
  localparam int HW       = DFW;
  localparam int NW       = 2 * CW;
  localparam int QB       = PW;
  localparam int DENW     = PW;
  localparam int SB       = DFW;
  localparam int RW       = COORD_WIDTH + 3;
  localparam int LAT      = scts_pkg::edge_latency(COORD_WIDTH);
  localparam int SIDE_LEN = LAT - 3;

  // stage 1: differences
  logic signed [DFW-1:0] s1_pax, s1_pay, s1_pbx, s1_pby, s1_bax, s1_bay;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pax <= DFW'(px) - DFW'(ax);
      s1_pay <= DFW'(py) - DFW'(ay);
      s1_pbx <= DFW'(px) - DFW'(bx);
      s1_pby <= DFW'(py) - DFW'(by);
      s1_bax <= DFW'(bx) - DFW'(ax);
      s1_bay <= DFW'(by) - DFW'(ay);
    end
  end

  // stage 2: products
  logic signed [PW-1:0] s2_t1x, s2_t1y, s2_t2x, s2_t2y, s2_crx, s2_cry;
  logic signed [PW-1:0] s2_pax2, s2_pay2, s2_pbx2, s2_pby2, s2_bax2, s2_bay2;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_t1x  <= s1_pax * s1_bax;
      s2_t1y  <= s1_pay * s1_bay;
      s2_t2x  <= s1_pbx * s1_bax;
      s2_t2y  <= s1_pby * s1_bay;
      s2_crx  <= s1_pax * s1_bay;
      s2_cry  <= s1_pay * s1_bax;
      s2_pax2 <= s1_pax * s1_pax;
      s2_pay2 <= s1_pay * s1_pay;
      s2_pbx2 <= s1_pbx * s1_pbx;
      s2_pby2 <= s1_pby * s1_pby;
      s2_bax2 <= s1_bax * s1_bax;
      s2_bay2 <= s1_bay * s1_bay;
    end
  end

  // stage 3: dot products, cross product, squared lengths
  logic signed [SW-1:0] s3_t1, s3_t2, s3_cr, s3_sqa, s3_sqb, s3_len;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_t1  <= SW'(s2_t1x) + SW'(s2_t1y);
      s3_t2  <= SW'(s2_t2x) + SW'(s2_t2y);
      s3_cr  <= SW'(s2_crx) - SW'(s2_cry);
      s3_sqa <= SW'(s2_pax2) + SW'(s2_pay2);
      s3_sqb <= SW'(s2_pbx2) + SW'(s2_pby2);
      s3_len <= SW'(s2_bax2) + SW'(s2_bay2);
    end
  end

  // stage 4: pick endpoint or perpendicular case
  logic            sel_a, sel_b;
  logic [SW-1:0]   cr_abs;
  scts_pkg::side_t s4_side_next;
  logic            s4_end;
  logic [QB-1:0]   s4_sq;
  logic [DENW-1:0] s4_len;
  logic [CW-1:0]   s4_crm;

  always_comb begin
    sel_a            = s3_t1[SW-1] || (s3_t1 == '0);
    sel_b            = !sel_a && !s3_t2[SW-1];
    cr_abs           = s3_cr[SW-1] ? -s3_cr : s3_cr;
    s4_side_next.neg = s3_cr[SW-1];
    s4_side_next.pos = !s3_cr[SW-1] && (s3_cr != '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_end <= sel_a || sel_b;
      s4_sq  <= sel_a ? s3_sqa[QB-1:0] : s3_sqb[QB-1:0];
      s4_len <= s3_len[DENW-1:0];
      s4_crm <= cr_abs[CW-1:0];
    end
  end

  // stage 5: square of the cross product in halves
  logic            s5_end;
  logic [QB-1:0]   s5_sq;
  logic [DENW-1:0] s5_len;
  logic [2*HW-1:0] s5_hh, s5_hl, s5_ll;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_end <= s4_end;
      s5_sq  <= s4_sq;
      s5_len <= s4_len;
      s5_hh  <= s4_crm[CW-1:HW] * s4_crm[CW-1:HW];
      s5_hl  <= s4_crm[CW-1:HW] * s4_crm[HW-1:0];
      s5_ll  <= s4_crm[HW-1:0] * s4_crm[HW-1:0];
    end
  end

  // stage 6 and divider: quotient of num by den, one bit a stage
  logic [NW-1:0]   dx [QB+1];
  logic [DENW-1:0] dd [QB];

  always_ff @(posedge clk) begin
    if (en) begin
      dx[0] <= s5_end ? NW'(s5_sq)
                      : (NW'(s5_hh) << CW) + (NW'(s5_hl) << (HW + 1)) + NW'(s5_ll);
      dd[0] <= s5_end ? DENW'(1) : s5_len;
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_div
    logic [NW:0]   t;
    logic [DENW:0] hi, hin;
    logic          ge;

    always_comb begin
      t   = {dx[j], 1'b0};
      hi  = t[NW:QB];
      ge  = hi >= {1'b0, dd[j]};
      hin = ge ? hi - {1'b0, dd[j]} : hi;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dx[j+1] <= {hin[DENW-1:0], t[QB-1:1], ge};
      end
    end

    if (j < QB - 1) begin : g_den
      always_ff @(posedge clk) begin
        if (en) begin
          dd[j+1] <= dd[j];
        end
      end
    end
  end

  // square root, one result bit a stage
  logic [QB-1:0] sr_rad [SB-1];
  logic [RW-1:0] sr_rem [SB-1];
  logic [SB-1:0] sr_res [SB];

  for (genvar k = 0; k < SB; k++) begin : g_sqrt
    logic [QB-1:0] rad_i;
    logic [RW-1:0] rem_i;
    logic [SB-1:0] res_i;
    logic [RW+1:0] r2, trial, rnew;
    logic          ge;

    if (k == 0) begin : g_first
      assign rad_i = dx[QB][QB-1:0];
      assign rem_i = '0;
      assign res_i = '0;
    end else begin : g_next
      assign rad_i = sr_rad[k-1];
      assign rem_i = sr_rem[k-1];
      assign res_i = sr_res[k-1];
    end

    always_comb begin
      r2    = {rem_i, rad_i[QB-1:QB-2]};
      trial = (RW + 2)'({res_i, 2'b01});
      ge    = r2 >= trial;
      rnew  = ge ? r2 - trial : r2;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sr_res[k] <= {res_i[SB-2:0], ge};
      end
    end

    if (k < SB - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          sr_rad[k] <= {rad_i[QB-3:0], 2'b00};
          sr_rem[k] <= rnew[RW-1:0];
        end
      end
    end
  end

  assign edist = sr_res[SB-1];

  // side flags ride alongside
  scts_pkg::side_t side_line [SIDE_LEN];

  always_ff @(posedge clk) begin
    if (en) begin
      side_line[0] <= s4_side_next;
      for (int i = 1; i < SIDE_LEN; i++) begin
        side_line[i] <= side_line[i-1];
      end
    end
  end

  assign side = side_line[SIDE_LEN-1];

endmodule

`default_nettype wire

// ===== design/segment_capsule_triangle_sdf.sv =====
// Signed distance from a stream of 2D points to a segment, capsule or triangle
// set by the configuration registers. One point is taken every cycle while the
// pipeline is not held. Each of the edge units AB, AC and BC holds a pipelined
// divider of 2*COORD_WIDTH+2 stages and a square root of COORD_WIDTH+1 stages.
// A stalled result moves into a skid register and the whole pipeline holds
// once the skid is full, so the input keeps accepting until a result is
// waiting in the skid.
// The user must write configuration only while no point is in flight; the
// block itself does not enforce it.
`default_nettype none

module segment_capsule_triangle_sdf #(
  parameter int COORD_WIDTH = scts_pkg::COORD_WIDTH_DEF
) (
  input  wire                                       clk,
  input  wire                                       rst,
  input  wire                                       s_tvalid,
  output logic                                      s_tready,
  // point_x, point_y
  input  wire [((2*COORD_WIDTH+7)/8)*8-1:0]         s_tdata,
  output logic                                      m_tvalid,
  input  wire                                       m_tready,
  // distance
  output logic [((COORD_WIDTH+2+7)/8)*8-1:0]        m_tdata,
  // inside_res
  output logic                                      m_tuser,
  input  wire                                       cfg_valid,
  output logic                                      cfg_ready,
  input  wire scts_pkg::reg_idx_t                   cfg_index,
  input  wire [COORD_WIDTH-1:0]                     cfg_data
);

  localparam int EL     = scts_pkg::edge_latency(COORD_WIDTH);
  localparam int DIST_W = COORD_WIDTH + 2;
  localparam int OUT_W  = ((COORD_WIDTH + 2 + 7) / 8) * 8;

  // configuration registers
  logic [1:0]                    shape_mode;
  logic signed [COORD_WIDTH-1:0] vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y;
  logic signed [COORD_WIDTH-1:0] vertex_c_x, vertex_c_y;
  logic [COORD_WIDTH-2:0]        radius;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      shape_mode <= '0;
      vertex_a_x <= '0;
      vertex_a_y <= '0;
      vertex_b_x <= '0;
      vertex_b_y <= '0;
      vertex_c_x <= '0;
      vertex_c_y <= '0;
      radius     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        scts_pkg::REG_SHAPE_MODE: shape_mode <= cfg_data[1:0];
        scts_pkg::REG_VERTEX_A_X: vertex_a_x <= cfg_data;
        scts_pkg::REG_VERTEX_A_Y: vertex_a_y <= cfg_data;
        scts_pkg::REG_VERTEX_B_X: vertex_b_x <= cfg_data;
        scts_pkg::REG_VERTEX_B_Y: vertex_b_y <= cfg_data;
        scts_pkg::REG_VERTEX_C_X: vertex_c_x <= cfg_data;
        scts_pkg::REG_VERTEX_C_Y: vertex_c_y <= cfg_data;
        scts_pkg::REG_RADIUS:     radius     <= cfg_data[COORD_WIDTH-2:0];
        default: ;
      endcase
    end
  end

  // pipeline advance
  logic skid_valid;
  logic en;
  logic v [EL+1];
  logic leave;

  assign en       = !skid_valid;
  assign s_tready = en;
  assign leave    = en && v[EL];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= EL; i++) begin
        v[i] <= 1'b0;
      end
    end else if (en) begin
      v[0] <= s_tvalid;
      for (int i = 1; i <= EL; i++) begin
        v[i] <= v[i-1];
      end
    end
  end

  // edge units
  logic signed [COORD_WIDTH-1:0] px, py;
  logic [COORD_WIDTH:0]          d_ab, d_ac, d_bc;
  scts_pkg::side_t               side_ab, side_ac, side_bc;

  assign px = s_tdata[COORD_WIDTH-1:0];
  assign py = s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];

  scts_edge #(.COORD_WIDTH(COORD_WIDTH)) u_edge_ab (
    .clk(clk), .en(en), .px(px), .py(py),
    .ax(vertex_a_x), .ay(vertex_a_y), .bx(vertex_b_x), .by(vertex_b_y),
    .edist(d_ab), .side(side_ab)
  );

  scts_edge #(.COORD_WIDTH(COORD_WIDTH)) u_edge_ac (
    .clk(clk), .en(en), .px(px), .py(py),
    .ax(vertex_a_x), .ay(vertex_a_y), .bx(vertex_c_x), .by(vertex_c_y),
    .edist(d_ac), .side(side_ac)
  );

  scts_edge #(.COORD_WIDTH(COORD_WIDTH)) u_edge_bc (
    .clk(clk), .en(en), .px(px), .py(py),
    .ax(vertex_b_x), .ay(vertex_b_y), .bx(vertex_c_x), .by(vertex_c_y),
    .edist(d_bc), .side(side_bc)
  );

  // combine the edges
  logic                 is_tri;
  logic [COORD_WIDTH:0] m1, min3;
  logic [COORD_WIDTH:0] f_dmin;
  logic                 f_inside, f_caps;

  always_comb begin
    is_tri = shape_mode == scts_pkg::MODE_TRIANGLE;
    m1     = (d_ac < d_ab) ? d_ac : d_ab;
    min3   = (d_bc < m1) ? d_bc : m1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_dmin   <= is_tri ? min3 : d_ab;
      f_inside <= is_tri && side_ab.neg && side_bc.neg && side_ac.pos;
      f_caps   <= shape_mode == scts_pkg::MODE_CAPSULE;
    end
  end

  logic [DIST_W-1:0] val;

  always_comb begin
    if (f_caps) begin
      val = {1'b0, f_dmin} - {3'b000, radius};
    end else if (f_inside) begin
      val = -{1'b0, f_dmin};
    end else begin
      val = {1'b0, f_dmin};
    end
  end

  // output register and skid
  logic [DIST_W-1:0] out_dist, skid_dist;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid   <= skid_valid || leave;
      skid_valid <= 1'b0;
    end else if (leave) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      out_dist <= skid_valid ? skid_dist : val;
    end else if (leave) begin
      skid_dist <= val;
    end
  end

  assign m_tdata = OUT_W'(out_dist);
  assign m_tuser = out_dist[DIST_W-1];

  // checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid holds a result while the output is empty");

  a_skid_from_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(m_tvalid) && !$past(m_tready))
    else $error("skid filled without an output stall");

  a_segment_positive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (shape_mode == scts_pkg::MODE_SEGMENT) |-> !m_tuser)
    else $error("negative distance in segment mode");

  a_frozen_pipe: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(v[EL]))
    else $error("pipeline moved while held");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int CW = 24;
  localparam int DW = CW + 2;

  typedef logic signed [255:0] wide_t;
  typedef struct {
    logic [DW-1:0] distance;
    logic          inside_res;
  } dist_res_t;

  logic               clk;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [47:0]        s_tdata;
  logic               m_tvalid;
  logic               m_tready;
  logic [31:0]        m_tdata;
  logic               m_tuser;
  logic               cfg_valid;
  logic               cfg_ready;
  scts_pkg::reg_idx_t cfg_index;
  logic [CW-1:0]      cfg_data;

  segment_capsule_triangle_sdf #(.COORD_WIDTH(CW)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // shadow copy of the shape registers
  logic [1:0]           shape;
  logic signed [CW-1:0] vax, vay, vbx, vby, vcx, vcy;
  logic [CW-2:0]        rad;

  dist_res_t expected_dist[$];
  int        errors = 0;
  int        cycle = 0;
  int        hold_until;
  int        idle_cycles = 0;
  bit        no_idle;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [63:0] floor_root(wide_t num, wide_t den);
    logic [63:0] d;
    logic [63:0] cand;
    wide_t       c;
    d = 0;
    for (int k = 37; k >= 0; k--) begin
      cand = d | (64'd1 << k);
      c = wide_t'(cand);
      if (c * c * den <= num) d = cand;
    end
    return d;
  endfunction

  function automatic logic [63:0] edge_dist(wide_t px, wide_t py, wide_t ax, wide_t ay,
                                            wide_t bx, wide_t by);
    wide_t pax, pay, pbx, pby, bax, bay, t1, t2, cr;
    pax = px - ax; pay = py - ay;
    pbx = px - bx; pby = py - by;
    bax = bx - ax; bay = by - ay;
    t1 = pax * bax + pay * bay;
    if (t1 <= 0) return floor_root(pax * pax + pay * pay, 1);
    t2 = pbx * bax + pby * bay;
    if (t2 >= 0) return floor_root(pbx * pbx + pby * pby, 1);
    cr = pax * bay - pay * bax;
    return floor_root(cr * cr, bax * bax + bay * bay);
  endfunction

  function automatic bit left_of(wide_t px, wide_t py, wide_t ax, wide_t ay,
                                 wide_t bx, wide_t by);
    return ((bx - ax) * (py - ay) - (by - ay) * (px - ax)) > 0;
  endfunction

  function automatic dist_res_t predict_dist(logic signed [CW-1:0] x, logic signed [CW-1:0] y);
    wide_t       px, py, ax, ay, bx, by, cx, cy;
    logic [63:0] d, d2, d3;
    longint      val;
    longint      lim;
    dist_res_t   r;
    px = x; py = y; ax = vax; ay = vay; bx = vbx; by = vby; cx = vcx; cy = vcy;
    lim = longint'(1) << (DW - 1);
    d = edge_dist(px, py, ax, ay, bx, by);
    if (shape == scts_pkg::MODE_CAPSULE) begin
      val = longint'(d) - longint'(rad);
    end else if (shape == scts_pkg::MODE_TRIANGLE) begin
      d2 = edge_dist(px, py, ax, ay, cx, cy);
      d3 = edge_dist(px, py, bx, by, cx, cy);
      if (d2 < d) d = d2;
      if (d3 < d) d = d3;
      val = longint'(d);
      if (left_of(px, py, ax, ay, bx, by) && left_of(px, py, bx, by, cx, cy) &&
          left_of(px, py, cx, cy, ax, ay))
        val = -val;
    end else begin
      val = longint'(d);
    end
    if (val > lim - 1) val = lim - 1;
    if (val < -lim) val = -lim;
    r.distance = val[DW-1:0];
    r.inside_res = val < 0;
    return r;
  endfunction

  task automatic write_reg(scts_pkg::reg_idx_t idx, logic [CW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      scts_pkg::REG_SHAPE_MODE: shape = value[1:0];
      scts_pkg::REG_VERTEX_A_X: vax = value;
      scts_pkg::REG_VERTEX_A_Y: vay = value;
      scts_pkg::REG_VERTEX_B_X: vbx = value;
      scts_pkg::REG_VERTEX_B_Y: vby = value;
      scts_pkg::REG_VERTEX_C_X: vcx = value;
      scts_pkg::REG_VERTEX_C_Y: vcy = value;
      scts_pkg::REG_RADIUS:     rad = value[CW-2:0];
      default: ;
    endcase
  endtask

  task automatic set_shape(logic [1:0] m, logic [CW-1:0] ax, logic [CW-1:0] ay,
                           logic [CW-1:0] bx, logic [CW-1:0] by,
                           logic [CW-1:0] cx, logic [CW-1:0] cy, logic [CW-1:0] r);
    write_reg(scts_pkg::REG_SHAPE_MODE, CW'(m));
    write_reg(scts_pkg::REG_VERTEX_A_X, ax);
    write_reg(scts_pkg::REG_VERTEX_A_Y, ay);
    write_reg(scts_pkg::REG_VERTEX_B_X, bx);
    write_reg(scts_pkg::REG_VERTEX_B_Y, by);
    write_reg(scts_pkg::REG_VERTEX_C_X, cx);
    write_reg(scts_pkg::REG_VERTEX_C_Y, cy);
    write_reg(scts_pkg::REG_RADIUS, r);
  endtask

  task automatic send_point(logic [CW-1:0] x, logic [CW-1:0] y);
    if (!no_idle) begin
      while ($urandom_range(99) < 31) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {y, x};
    do @(posedge clk); while (!s_tready);
    expected_dist.push_back(predict_dist(x, y));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_dist.size() != 0) @(posedge clk);
  endtask

  function automatic logic [CW-1:0] rand_coord(bit full);
    if (full) return CW'($urandom);
    return CW'($urandom_range(32767)) - CW'(16384);
  endfunction

  task automatic test_segment();
    set_shape(scts_pkg::MODE_SEGMENT, -24'sd4096, 24'sd0, 24'sd4096, 24'sd0, 0, 0, 0);
    send_point(24'sd0, 24'sd8192);
    send_point(-24'sd12288, 24'sd0);
    send_point(24'sd12288, 24'sd4096);
    send_point(24'h800000, 24'h800000);
    send_point(24'h7fffff, 24'h7fffff);
    send_point(24'h7fffff, 24'h800000);
    wait_drained();
    // degenerate segment and the unused mode code
    set_shape(2'd3, 24'h7fffff, 24'h800000, 24'h7fffff, 24'h800000, 0, 0, 0);
    send_point(24'h800000, 24'h7fffff);
    send_point(24'sd0, 24'sd0);
    send_point(24'h7fffff, 24'h800000);
    wait_drained();
  endtask

  task automatic test_capsule();
    set_shape(scts_pkg::MODE_CAPSULE, 0, 0, 24'sd40960, 24'sd40960, 0, 0, 24'sd8192);
    send_point(24'sd20480, 24'sd20480);
    send_point(24'sd20480, 24'sd0);
    send_point(-24'sd40960, 24'sd0);
    wait_drained();
    write_reg(scts_pkg::REG_RADIUS, 24'hffffff);
    send_point(24'h7fffff, 24'h800000);
    send_point(24'sd0, 24'sd0);
    wait_drained();
  endtask

  task automatic test_triangle();
    // counterclockwise, so interior points come out negative
    set_shape(scts_pkg::MODE_TRIANGLE, 0, 0, 24'sd40960, 0, 0, 24'sd40960, 0);
    send_point(24'sd4096, 24'sd4096);
    send_point(24'sd8192, 24'sd0);
    send_point(24'sd20480, 24'sd20480);
    send_point(-24'sd4096, -24'sd4096);
    send_point(24'sd0, 24'sd0);
    wait_drained();
    // clockwise order never reads as inside
    write_reg(scts_pkg::REG_VERTEX_B_X, 0);
    write_reg(scts_pkg::REG_VERTEX_B_Y, 24'sd40960);
    write_reg(scts_pkg::REG_VERTEX_C_X, 24'sd40960);
    write_reg(scts_pkg::REG_VERTEX_C_Y, 0);
    send_point(24'sd4096, 24'sd4096);
    send_point(24'h800000, 24'h7fffff);
    wait_drained();
  endtask

  task automatic test_backpressure();
    set_shape(scts_pkg::MODE_TRIANGLE, 0, 0, 24'sd65536, 0, 0, 24'sd65536, 0);
    no_idle = 1;
    hold_until = cycle + 400;
    for (int i = 0; i < 150; i++) send_point(rand_coord(0), rand_coord(0));
    no_idle = 0;
    wait_drained();
  endtask

  task automatic test_random();
    bit full;
    logic [1:0] m;
    for (int ph = 0; ph < 9; ph++) begin
      full = (ph % 3) == 2;
      m = (ph == 8) ? 2'd3 : 2'(ph % 3);
      set_shape(m, rand_coord(full), rand_coord(full), rand_coord(full), rand_coord(full),
                rand_coord(full), rand_coord(full),
                full ? CW'($urandom) : CW'($urandom_range(16384)));
      no_idle = (ph == 4);
      for (int i = 0; i < 55; i++) begin
        if ($urandom_range(9) == 0) send_point(CW'($urandom), CW'($urandom));
        else send_point(rand_coord(full), rand_coord(full));
      end
      no_idle = 0;
      wait_drained();
    end
  endtask

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle < hold_until) m_tready <= 1'b0;
    else m_tready <= no_idle || ($urandom_range(99) >= 31);
  end

  always @(posedge clk) begin
    dist_res_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_dist.size() == 0) begin
        $display("%0t: unexpected transaction, distance %0d inside %0b", $time,
                 $signed(m_tdata[DW-1:0]), m_tuser);
        errors++;
      end else begin
        e = expected_dist.pop_front();
        if (m_tdata[DW-1:0] !== e.distance) begin
          $display("%0t: distance expected %0d actual %0d", $time, $signed(e.distance),
                   $signed(m_tdata[DW-1:0]));
          errors++;
        end
        if (m_tuser !== e.inside_res) begin
          $display("%0t: inside expected %0b actual %0b", $time, e.inside_res, m_tuser);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("** segment_capsule_triangle_sdf: FAILED **");
      $finish;
    end
  end

  initial begin
    hold_until = 0;
    no_idle = 0;
    shape = 0; vax = 0; vay = 0; vbx = 0; vby = 0; vcx = 0; vcy = 0; rad = 0;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= scts_pkg::REG_SHAPE_MODE;
    cfg_data <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_segment();
    test_capsule();
    test_triangle();
    test_backpressure();
    test_random();
    wait_drained();
    repeat (120) @(posedge clk);
    if (errors == 0 && expected_dist.size() == 0) begin
      $display("** segment_capsule_triangle_sdf: PASSED **");
    end else begin
      $display("** segment_capsule_triangle_sdf: FAILED **");
    end
    $finish;
  end

endmodule
